// ===== sv/rtch_pkg.sv =====
// Shared types, constants and helper functions for the closest-hit ray/triangle core.
// Used by rtch_ctrl, rtch_dp and the top level; depends on nothing.
package rtch_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int INDEX_BITS = 24;
  localparam int WORD_W     = 32;
  localparam int EPS_W      = 16;
  localparam int BARY_W     = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int PROD_W     = 2 * WORD_W;
  localparam int TERM_W     = PROD_W - FRAC_BITS;
  localparam int ACC_W      = TERM_W + 2;
  localparam int QUO_W      = WORD_W + FRAC_BITS;
  localparam int DIV_ITERS  = QUO_W;
  localparam int ITER_W     = $clog2(DIV_ITERS);
  localparam int NUM_STEPS  = 24;
  localparam int STEP_W     = $clog2(NUM_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_DET_EPS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_T_EPS   = CFG_IDX_W'(1);
  localparam logic                 ACT_RAY     = 1'b0;

  localparam logic signed [WORD_W-1:0] S32_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] S32_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic signed [WORD_W-1:0] FX_ONE  = WORD_W'(1) <<< FRAC_BITS;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_ACC, ST_CHK, ST_DLOAD, ST_DRUN, ST_DEND, ST_UPD, ST_EMIT
  } state_t;

  typedef enum logic [1:0] { DIV_U, DIV_V, DIV_T } div_sel_t;

  typedef enum logic [2:0] { SRC_D, SRC_E1, SRC_E2, SRC_S, SRC_H, SRC_Q } src_t;

  typedef enum logic [2:0] {
    DST_H, DST_Q, DST_DET, DST_UNUM, DST_VNUM, DST_TNUM
  } dst_t;

  typedef struct packed {
    src_t       a;
    logic [1:0] ai;
    src_t       b;
    logic [1:0] bi;
    logic       neg;
    logic       first;
    logic       last;
    dst_t       dst;
    logic [1:0] di;
  } mul_op_t;

  typedef struct packed {
    logic              load_ray;
    logic              load_tri;
    logic              mul;
    logic              acc;
    logic [STEP_W-1:0] step;
    logic              div_load;
    logic              div_iter;
    logic              div_store;
    div_sel_t          div_sel;
    logic              upd;
    logic              emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic det_ok;
    logic out_busy;
  } dp_sts_t;

  // Product schedule: h = d x e2, det = e1.h, unum = s.h, q = s x e1,
  // vnum = d.q, tnum = e2.q
  function automatic mul_op_t mul_op(input logic [STEP_W-1:0] step);
    mul_op_t op;
    op = '{a: SRC_D, ai: 2'd0, b: SRC_D, bi: 2'd0, neg: 1'b0, first: 1'b0,
           last: 1'b0, dst: DST_H, di: 2'd0};
    unique case (step)
      5'd0:  op = '{SRC_D,  2'd1, SRC_E2, 2'd2, 1'b0, 1'b1, 1'b0, DST_H,    2'd0};
      5'd1:  op = '{SRC_D,  2'd2, SRC_E2, 2'd1, 1'b1, 1'b0, 1'b1, DST_H,    2'd0};
      5'd2:  op = '{SRC_D,  2'd2, SRC_E2, 2'd0, 1'b0, 1'b1, 1'b0, DST_H,    2'd1};
      5'd3:  op = '{SRC_D,  2'd0, SRC_E2, 2'd2, 1'b1, 1'b0, 1'b1, DST_H,    2'd1};
      5'd4:  op = '{SRC_D,  2'd0, SRC_E2, 2'd1, 1'b0, 1'b1, 1'b0, DST_H,    2'd2};
      5'd5:  op = '{SRC_D,  2'd1, SRC_E2, 2'd0, 1'b1, 1'b0, 1'b1, DST_H,    2'd2};
      5'd6:  op = '{SRC_E1, 2'd0, SRC_H,  2'd0, 1'b0, 1'b1, 1'b0, DST_DET,  2'd0};
      5'd7:  op = '{SRC_E1, 2'd1, SRC_H,  2'd1, 1'b0, 1'b0, 1'b0, DST_DET,  2'd0};
      5'd8:  op = '{SRC_E1, 2'd2, SRC_H,  2'd2, 1'b0, 1'b0, 1'b1, DST_DET,  2'd0};
      5'd9:  op = '{SRC_S,  2'd0, SRC_H,  2'd0, 1'b0, 1'b1, 1'b0, DST_UNUM, 2'd0};
      5'd10: op = '{SRC_S,  2'd1, SRC_H,  2'd1, 1'b0, 1'b0, 1'b0, DST_UNUM, 2'd0};
      5'd11: op = '{SRC_S,  2'd2, SRC_H,  2'd2, 1'b0, 1'b0, 1'b1, DST_UNUM, 2'd0};
      5'd12: op = '{SRC_S,  2'd1, SRC_E1, 2'd2, 1'b0, 1'b1, 1'b0, DST_Q,    2'd0};
      5'd13: op = '{SRC_S,  2'd2, SRC_E1, 2'd1, 1'b1, 1'b0, 1'b1, DST_Q,    2'd0};
      5'd14: op = '{SRC_S,  2'd2, SRC_E1, 2'd0, 1'b0, 1'b1, 1'b0, DST_Q,    2'd1};
      5'd15: op = '{SRC_S,  2'd0, SRC_E1, 2'd2, 1'b1, 1'b0, 1'b1, DST_Q,    2'd1};
      5'd16: op = '{SRC_S,  2'd0, SRC_E1, 2'd1, 1'b0, 1'b1, 1'b0, DST_Q,    2'd2};
      5'd17: op = '{SRC_S,  2'd1, SRC_E1, 2'd0, 1'b1, 1'b0, 1'b1, DST_Q,    2'd2};
      5'd18: op = '{SRC_D,  2'd0, SRC_Q,  2'd0, 1'b0, 1'b1, 1'b0, DST_VNUM, 2'd0};
      5'd19: op = '{SRC_D,  2'd1, SRC_Q,  2'd1, 1'b0, 1'b0, 1'b0, DST_VNUM, 2'd0};
      5'd20: op = '{SRC_D,  2'd2, SRC_Q,  2'd2, 1'b0, 1'b0, 1'b1, DST_VNUM, 2'd0};
      5'd21: op = '{SRC_E2, 2'd0, SRC_Q,  2'd0, 1'b0, 1'b1, 1'b0, DST_TNUM, 2'd0};
      5'd22: op = '{SRC_E2, 2'd1, SRC_Q,  2'd1, 1'b0, 1'b0, 1'b0, DST_TNUM, 2'd0};
      5'd23: op = '{SRC_E2, 2'd2, SRC_Q,  2'd2, 1'b0, 1'b0, 1'b1, DST_TNUM, 2'd0};
      default: ;
    endcase
    return op;
  endfunction

  function automatic logic signed [WORD_W-1:0] sat_acc(input logic signed [ACC_W-1:0] x);
    if (x > ACC_W'(S32_MAX)) return S32_MAX;
    if (x < ACC_W'(S32_MIN)) return S32_MIN;
    return x[WORD_W-1:0];
  endfunction

  function automatic logic signed [WORD_W-1:0] sat_sub(input logic signed [WORD_W-1:0] a,
                                                       input logic signed [WORD_W-1:0] b);
    logic signed [WORD_W:0] d;
    d = {a[WORD_W-1], a} - {b[WORD_W-1], b};
    if (d[WORD_W] != d[WORD_W-1]) return d[WORD_W] ? S32_MIN : S32_MAX;
    return d[WORD_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] abs_w(input logic signed [WORD_W-1:0] x);
    return x[WORD_W-1] ? WORD_W'(-x) : WORD_W'(x);
  endfunction

endpackage

// ===== sv/rtch_ctrl.sv =====
// Sequencer for the closest-hit core: steps the product schedule, the three
// quotients and the result hand-off. Depends on rtch_pkg.
module rtch_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_action,
  input  logic              in_last_tri,
  output logic              in_ready,
  input  rtch_pkg::dp_sts_t sts,
  output rtch_pkg::ctl_cmd_t cmd
);

  rtch_pkg::state_t                 state_r, state_nxt;
  logic [rtch_pkg::STEP_W-1:0]      step_r, step_nxt;
  logic [rtch_pkg::ITER_W-1:0]      iter_r, iter_nxt;
  rtch_pkg::div_sel_t               sel_r, sel_nxt;
  logic                             last_r, last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtch_pkg::ST_IDLE;
      step_r  <= '0;
      iter_r  <= '0;
      sel_r   <= rtch_pkg::DIV_U;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      iter_r  <= iter_nxt;
      sel_r   <= sel_nxt;
      last_r  <= last_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    iter_nxt    = iter_r;
    sel_nxt     = sel_r;
    last_nxt    = last_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.step    = step_r;
    cmd.div_sel = sel_r;
    unique case (state_r)
      rtch_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == rtch_pkg::ACT_RAY) begin
            cmd.load_ray = 1'b1;
          end else begin
            cmd.load_tri = 1'b1;
            last_nxt     = in_last_tri;
            step_nxt     = '0;
            state_nxt    = rtch_pkg::ST_MUL;
          end
        end
      end
      rtch_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = rtch_pkg::ST_ACC;
      end
      rtch_pkg::ST_ACC: begin
        cmd.acc = 1'b1;
        if (step_r == rtch_pkg::STEP_W'(rtch_pkg::NUM_STEPS - 1)) begin
          state_nxt = rtch_pkg::ST_CHK;
        end else begin
          step_nxt  = step_r + 1'b1;
          state_nxt = rtch_pkg::ST_MUL;
        end
      end
      rtch_pkg::ST_CHK: begin
        if (sts.det_ok) begin
          sel_nxt   = rtch_pkg::DIV_U;
          state_nxt = rtch_pkg::ST_DLOAD;
        end else begin
          state_nxt = last_r ? rtch_pkg::ST_EMIT : rtch_pkg::ST_IDLE;
        end
      end
      rtch_pkg::ST_DLOAD: begin
        cmd.div_load = 1'b1;
        iter_nxt     = '0;
        state_nxt    = rtch_pkg::ST_DRUN;
      end
      rtch_pkg::ST_DRUN: begin
        cmd.div_iter = 1'b1;
        if (iter_r == rtch_pkg::ITER_W'(rtch_pkg::DIV_ITERS - 1)) begin
          state_nxt = rtch_pkg::ST_DEND;
        end else begin
          iter_nxt = iter_r + 1'b1;
        end
      end
      rtch_pkg::ST_DEND: begin
        cmd.div_store = 1'b1;
        unique case (sel_r)
          rtch_pkg::DIV_U: begin
            sel_nxt   = rtch_pkg::DIV_V;
            state_nxt = rtch_pkg::ST_DLOAD;
          end
          rtch_pkg::DIV_V: begin
            sel_nxt   = rtch_pkg::DIV_T;
            state_nxt = rtch_pkg::ST_DLOAD;
          end
          default: state_nxt = rtch_pkg::ST_UPD;
        endcase
      end
      rtch_pkg::ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = last_r ? rtch_pkg::ST_EMIT : rtch_pkg::ST_IDLE;
      end
      rtch_pkg::ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = rtch_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rtch_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== sv/rtch_dp.sv =====
// Datapath for the closest-hit core: ray and edge registers, one shared
// multiplier with accumulator, a radix-2 divider, best-hit and result registers.
// Depends on rtch_pkg.
module rtch_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  rtch_pkg::ctl_cmd_t                     cmd,
  output rtch_pkg::dp_sts_t                      sts,
  input  logic                                   cfg_valid,
  input  logic [rtch_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [rtch_pkg::EPS_W-1:0]             cfg_data,
  input  logic signed [rtch_pkg::WORD_W-1:0]     in_ax, in_ay, in_az,
  input  logic signed [rtch_pkg::WORD_W-1:0]     in_bx, in_by, in_bz,
  input  logic signed [rtch_pkg::WORD_W-1:0]     in_cx, in_cy, in_cz,
  input  logic [rtch_pkg::INDEX_BITS-1:0]        in_tri_id,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_hit,
  output logic [rtch_pkg::WORD_W-2:0]            out_hit_t,
  output logic [rtch_pkg::BARY_W-1:0]            out_hit_u,
  output logic [rtch_pkg::BARY_W-1:0]            out_hit_v,
  output logic [rtch_pkg::INDEX_BITS-1:0]        out_hit_index
);

  localparam int W = rtch_pkg::WORD_W;

  logic [rtch_pkg::EPS_W-1:0] det_eps_r, t_eps_r;
  logic signed [W-1:0] org_r [3];
  logic signed [W-1:0] dir_r [3];
  logic signed [W-1:0] e1_r  [3];
  logic signed [W-1:0] e2_r  [3];
  logic signed [W-1:0] s_r   [3];
  logic signed [W-1:0] h_r   [3];
  logic signed [W-1:0] q_r   [3];
  logic signed [W-1:0] det_r, unum_r, vnum_r, tnum_r, u_r, v_r, t_r;
  logic [rtch_pkg::INDEX_BITS-1:0] id_r;

  logic signed [rtch_pkg::PROD_W-1:0] prod_r;
  logic signed [rtch_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [rtch_pkg::TERM_W-1:0] term;
  logic signed [W-1:0]                opa, opb, acc_sat;
  rtch_pkg::mul_op_t                  op;

  logic [rtch_pkg::QUO_W-1:0] dq_r;
  logic [W-1:0]               rem_r;
  logic                       neg_r;
  logic [W:0]                 rem_sh;
  logic                       rem_ge;
  logic signed [W-1:0]        div_num, quo_sat;
  logic [W-1:0]               dmag, adet;

  logic signed [W-1:0]        best_t_r;
  logic [rtch_pkg::BARY_W-1:0] best_u_r, best_v_r;
  logic [rtch_pkg::INDEX_BITS-1:0] best_id_r;
  logic                       found_r, keep;
  logic signed [W:0]          uv_sum;

  logic                       out_valid_r;
  logic                       out_hit_r;
  logic [W-2:0]               out_t_r;
  logic [rtch_pkg::BARY_W-1:0] out_u_r, out_v_r;
  logic [rtch_pkg::INDEX_BITS-1:0] out_id_r;

  function automatic logic signed [W-1:0] pick(input rtch_pkg::src_t src, input logic [1:0] i,
      input logic signed [W-1:0] d [3], input logic signed [W-1:0] a [3],
      input logic signed [W-1:0] b [3], input logic signed [W-1:0] s [3],
      input logic signed [W-1:0] h [3], input logic signed [W-1:0] q [3]);
    unique case (src)
      rtch_pkg::SRC_D:  return d[i];
      rtch_pkg::SRC_E1: return a[i];
      rtch_pkg::SRC_E2: return b[i];
      rtch_pkg::SRC_S:  return s[i];
      rtch_pkg::SRC_H:  return h[i];
      default:          return q[i];
    endcase
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_eps_r <= rtch_pkg::EPS_W'(1);
      t_eps_r   <= rtch_pkg::EPS_W'(1);
    end else if (cfg_valid) begin
      if (cfg_index == rtch_pkg::CFG_DET_EPS) det_eps_r <= cfg_data;
      if (cfg_index == rtch_pkg::CFG_T_EPS)   t_eps_r   <= cfg_data;
    end
  end

  // Ray registers and per-triangle edge vectors
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        org_r[i] <= '0;
        dir_r[i] <= '0;
      end
    end else if (cmd.load_ray) begin
      org_r[0] <= in_ax; org_r[1] <= in_ay; org_r[2] <= in_az;
      dir_r[0] <= in_bx; dir_r[1] <= in_by; dir_r[2] <= in_bz;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_tri) begin
      e1_r[0] <= rtch_pkg::sat_sub(in_bx, in_ax);
      e1_r[1] <= rtch_pkg::sat_sub(in_by, in_ay);
      e1_r[2] <= rtch_pkg::sat_sub(in_bz, in_az);
      e2_r[0] <= rtch_pkg::sat_sub(in_cx, in_ax);
      e2_r[1] <= rtch_pkg::sat_sub(in_cy, in_ay);
      e2_r[2] <= rtch_pkg::sat_sub(in_cz, in_az);
      s_r[0]  <= rtch_pkg::sat_sub(org_r[0], in_ax);
      s_r[1]  <= rtch_pkg::sat_sub(org_r[1], in_ay);
      s_r[2]  <= rtch_pkg::sat_sub(org_r[2], in_az);
      id_r    <= in_tri_id;
    end
  end

  // Shared multiplier, then floor-shift and accumulate
  always_comb begin
    op   = rtch_pkg::mul_op(cmd.step);
    opa  = pick(op.a, op.ai, dir_r, e1_r, e2_r, s_r, h_r, q_r);
    opb  = pick(op.b, op.bi, dir_r, e1_r, e2_r, s_r, h_r, q_r);
    term = rtch_pkg::TERM_W'(prod_r >>> rtch_pkg::FRAC_BITS);
    if (op.first) begin
      acc_nxt = op.neg ? -rtch_pkg::ACC_W'(term) : rtch_pkg::ACC_W'(term);
    end else begin
      acc_nxt = op.neg ? acc_r - rtch_pkg::ACC_W'(term) : acc_r + rtch_pkg::ACC_W'(term);
    end
    acc_sat = rtch_pkg::sat_acc(acc_nxt);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) prod_r <= rtch_pkg::PROD_W'(opa * opb);
    if (cmd.acc) begin
      acc_r <= acc_nxt;
      if (op.last) begin
        unique case (op.dst)
          rtch_pkg::DST_H:    h_r[op.di] <= acc_sat;
          rtch_pkg::DST_Q:    q_r[op.di] <= acc_sat;
          rtch_pkg::DST_DET:  det_r      <= acc_sat;
          rtch_pkg::DST_UNUM: unum_r     <= acc_sat;
          rtch_pkg::DST_VNUM: vnum_r     <= acc_sat;
          default:            tnum_r     <= acc_sat;
        endcase
      end
    end
  end

  assign adet       = rtch_pkg::abs_w(det_r);
  assign sts.det_ok = (det_r != '0) && (adet >= W'(det_eps_r));

  // Restoring divider on magnitudes, one quotient bit per cycle
  always_comb begin
    unique case (cmd.div_sel)
      rtch_pkg::DIV_U: div_num = unum_r;
      rtch_pkg::DIV_V: div_num = vnum_r;
      default:         div_num = tnum_r;
    endcase
    dmag   = adet;
    rem_sh = {rem_r, dq_r[rtch_pkg::QUO_W-1]};
    rem_ge = rem_sh >= {1'b0, dmag};
    if (!neg_r) begin
      quo_sat = (dq_r > rtch_pkg::QUO_W'(rtch_pkg::S32_MAX)) ? rtch_pkg::S32_MAX
                                                             : W'(dq_r);
    end else begin
      quo_sat = (dq_r > rtch_pkg::QUO_W'({1'b0, rtch_pkg::S32_MIN})) ? rtch_pkg::S32_MIN
                                                                     : -W'(dq_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dq_r  <= {rtch_pkg::abs_w(div_num), rtch_pkg::FRAC_BITS'(0)};
      rem_r <= '0;
      neg_r <= div_num[W-1] ^ det_r[W-1];
    end else if (cmd.div_iter) begin
      rem_r <= rem_ge ? W'(rem_sh - {1'b0, dmag}) : W'(rem_sh);
      dq_r  <= {dq_r[rtch_pkg::QUO_W-2:0], rem_ge};
    end
    if (cmd.div_store) begin
      unique case (cmd.div_sel)
        rtch_pkg::DIV_U: u_r <= quo_sat;
        rtch_pkg::DIV_V: v_r <= quo_sat;
        default:         t_r <= quo_sat;
      endcase
    end
  end

  // Range tests and best-hit update
  assign uv_sum = {u_r[W-1], u_r} + {v_r[W-1], v_r};
  assign keep = !u_r[W-1] && (u_r <= rtch_pkg::FX_ONE) && !v_r[W-1]
             && (uv_sum <= (W+1)'(rtch_pkg::FX_ONE))
             && (t_r > $signed({1'b0, (W-1)'(t_eps_r)})) && (t_r < best_t_r);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_ray) begin
      best_t_r  <= rtch_pkg::S32_MAX;
      best_u_r  <= '0;
      best_v_r  <= '0;
      best_id_r <= '0;
      found_r   <= 1'b0;
    end else if (cmd.upd && keep) begin
      best_t_r  <= t_r;
      best_u_r  <= u_r[rtch_pkg::BARY_W-1:0];
      best_v_r  <= v_r[rtch_pkg::BARY_W-1:0];
      best_id_r <= id_r;
      found_r   <= 1'b1;
    end
  end

  // Output register: holds the result while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_hit_r <= found_r;
      out_t_r   <= best_t_r[W-2:0];
      out_u_r   <= best_u_r;
      out_v_r   <= best_v_r;
      out_id_r  <= best_id_r;
    end
  end

  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_hit_t     = out_t_r;
  assign out_hit_u     = out_u_r;
  assign out_hit_v     = out_v_r;
  assign out_hit_index = out_id_r;

endmodule

// ===== sv/ray_triangle_closest_hit_core.sv =====
// Top level of the closest-hit ray/triangle core: joins rtch_ctrl and rtch_dp.
// Depends on rtch_pkg, rtch_ctrl and rtch_dp.
//
// Usage: send a ray item (in_action = 0) with origin in a* and direction in b*;
// it loads the ray and clears the best hit. Then send triangle
// items (in_action = 1), vertices in a*, b*, c*, tag in in_tri_id. The triangle
// with in_last_tri set produces one transfer on the out_ channel with the
// closest hit since the last ray item; the best hit is kept afterwards.
// Sequence: one triangle at a time. A triangle runs 24 products through one shared
// 32x32 multiplier, each in a multiply state then an accumulate state, then a
// determinant check; if the determinant passes, three quotients run through a
// one-bit-per-cycle divider, then an update step. After the update, or after a
// failed check on the last triangle, the emit state loads the result register
// once the previous result is no longer stalled. The divider sets pace.
// Stall: the result stays in the output register until out_ready; the core
// takes the next item meanwhile and waits only if a new result is due.
// Reset (rst_n low, synchronous): control idle, ray zero, best hit cleared,
// det_epsilon and t_epsilon back to 1. cfg_ready is always high.
module ray_triangle_closest_hit_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rtch_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [rtch_pkg::EPS_W-1:0]             cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_action,
  input  logic signed [rtch_pkg::WORD_W-1:0]     in_ax,
  input  logic signed [rtch_pkg::WORD_W-1:0]     in_ay,
  input  logic signed [rtch_pkg::WORD_W-1:0]     in_az,
  input  logic signed [rtch_pkg::WORD_W-1:0]     in_bx,
  input  logic signed [rtch_pkg::WORD_W-1:0]     in_by,
  input  logic signed [rtch_pkg::WORD_W-1:0]     in_bz,
  input  logic signed [rtch_pkg::WORD_W-1:0]     in_cx,
  input  logic signed [rtch_pkg::WORD_W-1:0]     in_cy,
  input  logic signed [rtch_pkg::WORD_W-1:0]     in_cz,
  input  logic [rtch_pkg::INDEX_BITS-1:0]        in_tri_id,
  input  logic                                   in_last_tri,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_hit,
  output logic [rtch_pkg::WORD_W-2:0]            out_hit_t,
  output logic [rtch_pkg::BARY_W-1:0]            out_hit_u,
  output logic [rtch_pkg::BARY_W-1:0]            out_hit_v,
  output logic [rtch_pkg::INDEX_BITS-1:0]        out_hit_index
);

  rtch_pkg::ctl_cmd_t cmd;
  rtch_pkg::dp_sts_t  sts;

  // Config writes go straight into the epsilon registers; never hold them off
  assign cfg_ready = 1'b1;

  rtch_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_action   (in_action),
    .in_last_tri (in_last_tri),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  rtch_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_ax         (in_ax),
    .in_ay         (in_ay),
    .in_az         (in_az),
    .in_bx         (in_bx),
    .in_by         (in_by),
    .in_bz         (in_bz),
    .in_cx         (in_cx),
    .in_cy         (in_cy),
    .in_cz         (in_cz),
    .in_tri_id     (in_tri_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hit       (out_hit),
    .out_hit_t     (out_hit_t),
    .out_hit_u     (out_hit_u),
    .out_hit_v     (out_hit_v),
    .out_hit_index (out_hit_index)
  );

endmodule

// ===== sv/rtch_checker.sv =====
// Port-level checks for ray_triangle_closest_hit_core, bound to the top level.
// Depends on rtch_pkg.
module rtch_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_action,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_hit,
  input logic [rtch_pkg::WORD_W-2:0]       out_hit_t,
  input logic [rtch_pkg::BARY_W-1:0]       out_hit_u,
  input logic [rtch_pkg::BARY_W-1:0]       out_hit_v,
  input logic [rtch_pkg::INDEX_BITS-1:0]   out_hit_index
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit_t) && $stable(out_hit_index))
    else $error("result dropped or changed while stalled");

  a_tri_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action |=> !in_ready)
    else $error("triangle accepted back to back");

  a_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> (out_hit_t == '1) && (out_hit_index == '0)
                              && (out_hit_u == '0) && (out_hit_v == '0))
    else $error("miss result carries hit data");

  a_bary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> (out_hit_u <= rtch_pkg::BARY_W'(65536))
                             && (out_hit_v <= rtch_pkg::BARY_W'(65536)))
    else $error("barycentric out of range");

endmodule

bind ray_triangle_closest_hit_core rtch_checker u_rtch_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_action     (in_action),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_hit       (out_hit),
  .out_hit_t     (out_hit_t),
  .out_hit_u     (out_hit_u),
  .out_hit_v     (out_hit_v),
  .out_hit_index (out_hit_index)
);

// ===== bench/testbench.sv =====
// Self-checking bench for ray_triangle_closest_hit_core: directed and random rays and
// triangles with a built-in closest-hit predictor. Depends on rtch_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;

  // One item on the input channel; ray items leave the c* fields unused.
  typedef struct {
    logic                    action;
    logic signed [rtch_pkg::WORD_W-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    logic [rtch_pkg::INDEX_BITS-1:0]   tri_id;
    logic                    last_tri;
  } geom_item_t;

  // One closest-hit report on the output channel.
  typedef struct {
    logic                  hit;
    logic [rtch_pkg::WORD_W-2:0]     t;
    logic [rtch_pkg::BARY_W-1:0]     u, v;
    logic [rtch_pkg::INDEX_BITS-1:0] idx;
  } hit_report_t;

  localparam longint ONE_FX   = longint'(1) << rtch_pkg::FRAC_BITS;
  localparam longint MAX_WORD = 64'sd2147483647;
  localparam longint MIN_WORD = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rtch_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rtch_pkg::EPS_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = 1'b0;
  logic signed [rtch_pkg::WORD_W-1:0] in_ax = '0, in_ay = '0, in_az = '0;
  logic signed [rtch_pkg::WORD_W-1:0] in_bx = '0, in_by = '0, in_bz = '0;
  logic signed [rtch_pkg::WORD_W-1:0] in_cx = '0, in_cy = '0, in_cz = '0;
  logic [rtch_pkg::INDEX_BITS-1:0] in_tri_id = '0;
  logic in_last_tri = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  logic [rtch_pkg::WORD_W-2:0] out_hit_t;
  logic [rtch_pkg::BARY_W-1:0] out_hit_u, out_hit_v;
  logic [rtch_pkg::INDEX_BITS-1:0] out_hit_index;

  ray_triangle_closest_hit_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_ax(in_ax), .in_ay(in_ay), .in_az(in_az),
    .in_bx(in_bx), .in_by(in_by), .in_bz(in_bz),
    .in_cx(in_cx), .in_cy(in_cy), .in_cz(in_cz),
    .in_tri_id(in_tri_id), .in_last_tri(in_last_tri),
    .out_valid(out_valid), .out_ready(out_ready), .out_hit(out_hit),
    .out_hit_t(out_hit_t), .out_hit_u(out_hit_u), .out_hit_v(out_hit_v),
    .out_hit_index(out_hit_index)
  );

  geom_item_t  geom_q[$];     // items waiting for the driver
  hit_report_t hit_q[$];      // reports predicted but not yet seen
  bit          failed = 0;
  bit          in_xfer = 0;   // set at the edge that accepted the driven item
  int          stall_pct = 0; // receiver back-pressure for the current phase

  // Predictor copy of the core state and registers.
  longint ray_o[3], ray_d[3];
  longint near_t, near_u, near_v;
  logic [rtch_pkg::INDEX_BITS-1:0] near_idx;
  bit     near_found;
  longint det_min = 1, t_min = 1;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic longint clamp_word(input longint x);
    if (x > MAX_WORD) return MAX_WORD;
    if (x < MIN_WORD) return MIN_WORD;
    return x;
  endfunction

  // Full 64-bit product, floor-shifted back to Q16.16.
  function automatic longint fx_mul(input longint a, input longint b);
    return (a * b) >>> rtch_pkg::FRAC_BITS;
  endfunction

  function automatic longint fx_div(input longint num, input longint den);
    return clamp_word((num * ONE_FX) / den);
  endfunction

  function automatic void vec_sub(input longint a[3], input longint b[3], output longint r[3]);
    for (int i = 0; i < 3; i++) r[i] = clamp_word(a[i] - b[i]);
  endfunction

  function automatic void vec_cross(input longint a[3], input longint b[3],
                                    output longint r[3]);
    r[0] = clamp_word(fx_mul(a[1], b[2]) - fx_mul(a[2], b[1]));
    r[1] = clamp_word(fx_mul(a[2], b[0]) - fx_mul(a[0], b[2]));
    r[2] = clamp_word(fx_mul(a[0], b[1]) - fx_mul(a[1], b[0]));
  endfunction

  function automatic longint vec_dot(input longint a[3], input longint b[3]);
    return clamp_word(fx_mul(a[0], b[0]) + fx_mul(a[1], b[1]) + fx_mul(a[2], b[2]));
  endfunction

  function automatic void clear_nearest();
    near_t = MAX_WORD;
    near_u = 0;
    near_v = 0;
    near_idx = '0;
    near_found = 0;
  endfunction

  // Moller-Trumbore test of one triangle against the held ray; keep the nearest hit.
  function automatic void test_triangle(input longint v0[3], input longint v1[3],
                                        input longint v2[3],
                                        input logic [rtch_pkg::INDEX_BITS-1:0] id);
    longint e1[3], e2[3], h[3], s[3], q[3];
    longint det, adet, u, v, t;
    vec_sub(v1, v0, e1);
    vec_sub(v2, v0, e2);
    vec_cross(ray_d, e2, h);
    det = vec_dot(e1, h);
    adet = det < 0 ? -det : det;
    if (det == 0 || adet < det_min) return;
    vec_sub(ray_o, v0, s);
    u = fx_div(vec_dot(s, h), det);
    if (u < 0 || u > ONE_FX) return;
    vec_cross(s, e1, q);
    v = fx_div(vec_dot(ray_d, q), det);
    if (v < 0 || u + v > ONE_FX) return;
    t = fx_div(vec_dot(e2, q), det);
    if (t > t_min && t < near_t) begin
      near_found = 1;
      near_t = t;
      near_u = u;
      near_v = v;
      near_idx = id;
    end
  endfunction

  function automatic void predict_hit(input geom_item_t it);
    longint a[3], b[3], c[3];
    hit_report_t r;
    a = '{longint'(it.ax), longint'(it.ay), longint'(it.az)};
    b = '{longint'(it.bx), longint'(it.by), longint'(it.bz)};
    c = '{longint'(it.cx), longint'(it.cy), longint'(it.cz)};
    if (it.action == rtch_pkg::ACT_RAY) begin
      ray_o = a;
      ray_d = b;
      clear_nearest();
      return;
    end
    test_triangle(a, b, c, it.tri_id);
    if (!it.last_tri) return;
    r.hit = near_found;
    r.t   = near_t[rtch_pkg::WORD_W-2:0];
    r.u   = near_u[rtch_pkg::BARY_W-1:0];
    r.v   = near_v[rtch_pkg::BARY_W-1:0];
    r.idx = near_idx;
    hit_q.push_back(r);
  endfunction

  // Sample transfers on all three channels at the rising edge.
  always @(posedge clk) begin
    hit_report_t e;
    if (!rst_n) begin
      ray_o = '{0, 0, 0};
      ray_d = '{0, 0, 0};
      clear_nearest();
      det_min = 1;
      t_min = 1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rtch_pkg::CFG_DET_EPS) det_min = cfg_data;
        else if (cfg_index == rtch_pkg::CFG_T_EPS) t_min = cfg_data;
      end
      if (in_valid && in_ready) begin
        predict_hit('{in_action, in_ax, in_ay, in_az, in_bx, in_by, in_bz,
                      in_cx, in_cy, in_cz, in_tri_id, in_last_tri});
        in_xfer = 1;
      end
      if (out_valid && out_ready) begin
        if (hit_q.size() == 0) begin
          $display("%0t: unexpected result hit=%0d t=%0h", $realtime, out_hit, out_hit_t);
          failed = 1;
        end else begin
          e = hit_q.pop_front();
          if (out_hit !== e.hit || out_hit_t !== e.t || out_hit_u !== e.u ||
              out_hit_v !== e.v || out_hit_index !== e.idx) begin
            $display("%0t: mismatch expected hit=%0d t=%0h u=%0h v=%0h idx=%0h",
                     $realtime, e.hit, e.t, e.u, e.v, e.idx);
            $display("%0t:          actual   hit=%0d t=%0h u=%0h v=%0h idx=%0h",
                     $realtime, out_hit, out_hit_t, out_hit_u, out_hit_v, out_hit_index);
            failed = 1;
          end
        end
      end
    end
  end

  // Driver: hold the item until its transfer, then send in bursts with random gaps.
  int gap_left = 0;
  int burst_left = 4;
  always @(negedge clk) begin
    geom_item_t it;
    if (rst_n && !(in_valid && !in_xfer)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (geom_q.size() > 0) begin
        it = geom_q.pop_front();
        in_action <= it.action;
        in_ax <= it.ax; in_ay <= it.ay; in_az <= it.az;
        in_bx <= it.bx; in_by <= it.by; in_bz <= it.bz;
        in_cx <= it.cx; in_cy <= it.cy; in_cz <= it.cz;
        in_tri_id <= it.tri_id;
        in_last_tri <= it.last_tri;
        in_valid <= 1'b1;
        if (--burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_xfer = 0;
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic geom_item_t ray_item(input longint ox, input longint oy,
                                          input longint oz, input longint dx,
                                          input longint dy, input longint dz);
    geom_item_t it;
    it = '{rtch_pkg::ACT_RAY, ox, oy, oz, dx, dy, dz, $urandom, $urandom, $urandom,
           $urandom, $urandom_range(0, 1)};
    return it;
  endfunction

  // Right triangle of leg w in the plane z = pz, vertex0 offset by (ox, oy) from (px, py).
  function automatic geom_item_t flat_tri(input longint px, input longint py, input longint pz,
                                          input longint ox, input longint oy, input longint w,
                                          input int id, input bit last);
    geom_item_t it;
    it = '{~rtch_pkg::ACT_RAY, px + ox, py + oy, pz, px + ox + w, py + oy, pz,
           px + ox, py + oy + w, pz, id, last};
    return it;
  endfunction

  function automatic geom_item_t noise_item();
    geom_item_t it;
    it = '{$urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1)};
    return it;
  endfunction

  // Well-formed scenes: a ray, then triangles placed near its path; some noise between.
  task automatic queue_random_scenes(input int n_items);
    longint ox, oy, oz, dx, dy, dz, w;
    int cnt, k;
    cnt = 0;
    while (cnt < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        ox = $signed($urandom_range(0, 16 * ONE_FX)) - 8 * ONE_FX;
        oy = $signed($urandom_range(0, 16 * ONE_FX)) - 8 * ONE_FX;
        oz = $signed($urandom_range(0, 16 * ONE_FX)) - 8 * ONE_FX;
        dx = $signed($urandom_range(0, ONE_FX / 4)) - ONE_FX / 8;
        dy = $signed($urandom_range(0, ONE_FX / 4)) - ONE_FX / 8;
        dz = $urandom_range(ONE_FX / 2, 2 * ONE_FX);
        geom_q.push_back(ray_item(ox, oy, oz, dx, dy, dz));
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++) begin
          w = $urandom_range(ONE_FX / 4, 8 * ONE_FX);
          geom_q.push_back(flat_tri(ox, oy,
                                    oz + $signed($urandom_range(0, 24 * ONE_FX)) - 4 * ONE_FX,
                                    -$signed($urandom_range(0, w + w / 4)) + w / 8,
                                    -$signed($urandom_range(0, w + w / 4)) + w / 8,
                                    w, $urandom, i == k - 1));
        end
        cnt += k + 1;
      end else begin
        geom_q.push_back(noise_item());
        cnt++;
      end
    end
  endtask

  task automatic write_reg(input logic [rtch_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rtch_pkg::EPS_W-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait for everything sent to be processed, then let a rejected triangle finish.
  task automatic wait_idle();
    while (geom_q.size() > 0 || in_valid || hit_q.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    geom_item_t it;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: ray along +z from the origin unless noted.
    geom_q.push_back(flat_tri(0, 0, 2 * ONE_FX, -ONE_FX / 4, -ONE_FX / 4, ONE_FX, 5, 1));
    geom_q.push_back(ray_item(0, 0, 0, 0, 0, ONE_FX));
    geom_q[$].last_tri = 1'b1;  // ray with last_tri set yields nothing
    geom_q.push_back(flat_tri(0, 0, 2 * ONE_FX, -ONE_FX / 4, -ONE_FX / 4, ONE_FX, 10, 0));
    // equal distance keeps the earlier triangle
    geom_q.push_back(flat_tri(0, 0, 2 * ONE_FX, -ONE_FX / 2, -ONE_FX / 4, ONE_FX, 11, 1));
    // accumulation continues past a result
    geom_q.push_back(flat_tri(0, 0, ONE_FX, -ONE_FX / 4, -ONE_FX / 4, ONE_FX, 12, 1));
    geom_q.push_back(ray_item(0, 0, 0, 0, 0, ONE_FX));
    geom_q.push_back(flat_tri(0, 0, ONE_FX, ONE_FX / 4, -ONE_FX / 4, ONE_FX, 20, 0));   // u < 0
    geom_q.push_back(flat_tri(0, 0, ONE_FX, -2 * ONE_FX, 0, ONE_FX, 21, 0));           // u > 1
    geom_q.push_back(flat_tri(0, 0, ONE_FX, -ONE_FX / 4, ONE_FX / 4, ONE_FX, 22, 0));   // v < 0
    geom_q.push_back(flat_tri(0, 0, ONE_FX, -3 * ONE_FX / 4, -3 * ONE_FX / 4, ONE_FX,
                              23, 0));                                                // u+v > 1
    geom_q.push_back(flat_tri(0, 0, -2 * ONE_FX, -ONE_FX / 4, -ONE_FX / 4, ONE_FX,
                              24, 0));                                                // behind
    geom_q.push_back(flat_tri(0, 0, 0, -ONE_FX / 4, -ONE_FX / 4, ONE_FX, 25, 0));      // t = 0
    geom_q.push_back(flat_tri(0, 0, ONE_FX, 0, 0, 0, 26, 1));                          // det = 0
    geom_q.push_back(flat_tri(0, 0, 3 * ONE_FX, -ONE_FX, 0, ONE_FX, 27, 1));          // u = 1
    geom_q.push_back(flat_tri(0, 0, 3 * ONE_FX, 0, -ONE_FX, ONE_FX, 28, 1));          // v = 1
    it = '{rtch_pkg::ACT_RAY, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
           32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
           '1, 1'b0};
    geom_q.push_back(it);
    it.action = ~rtch_pkg::ACT_RAY;
    it.last_tri = 1'b1;
    geom_q.push_back(it);
    it = '{~rtch_pkg::ACT_RAY, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
           32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh80000000,
           '1, 1'b1};
    geom_q.push_back(it);
    wait_idle();

    // Random scenes under several register settings, draining between them.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(rtch_pkg::CFG_DET_EPS, 0);
          write_reg(rtch_pkg::CFG_T_EPS, 0);
        end
        1: begin
          write_reg(rtch_pkg::CFG_DET_EPS, '1);
          write_reg(rtch_pkg::CFG_T_EPS, '1);
        end
        2: begin
          write_reg(rtch_pkg::CFG_DET_EPS, $urandom);
          write_reg(rtch_pkg::CFG_T_EPS, $urandom);
          write_reg(rtch_pkg::CFG_IDX_W'(2), $urandom);
          write_reg(rtch_pkg::CFG_IDX_W'(3), $urandom);
        end
        3: begin
          write_reg(rtch_pkg::CFG_DET_EPS, 1);
          write_reg(rtch_pkg::CFG_T_EPS, 1);
        end
        default: begin
          write_reg(rtch_pkg::CFG_DET_EPS, $urandom_range(0, 255));
          write_reg(rtch_pkg::CFG_T_EPS, $urandom_range(0, 4095));
        end
      endcase
      stall_pct = (ph == 3) ? 0 : $urandom_range(10, 80);
      queue_random_scenes(80);
      wait_idle();
    end

    if (!failed && hit_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/rtch_pkg.sv
sv/rtch_ctrl.sv
sv/rtch_dp.sv
sv/ray_triangle_closest_hit_core.sv
sv/rtch_checker.sv
bench/testbench.sv
